[design/wcsp_pkg.sv]
// wcsp_pkg: shared types and constants of the wav chunk stream parser
// used by every module of the parser; depends on nothing

package wcsp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned CHAIN_W           = 34;

  localparam int unsigned MIN_FILE_LEN      = 44;
  localparam int unsigned PREAMBLE_LEN      = 12;
  localparam int unsigned HDR_LEN           = 8;
  localparam int unsigned FMT_OFS_CHANNELS  = 8 + 2;
  localparam int unsigned FMT_OFS_RATE      = 8 + 4;
  localparam int unsigned FMT_OFS_BITS      = 8 + 14;

  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_NO_FMT  = 2'd2;
  localparam logic [1:0] ST_NO_DATA = 2'd3;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } wcsp_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic        final_res;
  } wcsp_out_t;

  typedef struct packed {
    logic      first_vld;
    wcsp_out_t first;
    logic      second_vld;
    wcsp_out_t second;
  } wcsp_pair_t;

endpackage

[design/wav_chunk_stream_parser_top.sv]
// wav_chunk_stream_parser_top: input register, parser and result stage
// depends on wcsp_pkg, wcsp_parse and wcsp_out
//
// Takes a WAV file one byte per item, with end_of_file on the last byte, and
// returns payload items for every byte after the first data chunk header plus
// one summary item (status and captured format, final_res set) for the last
// byte. One byte is taken per clock while in_stall_o is low; a byte waits in
// the input register and its result in the result register, which holds it
// while out_stall_i is high. A last byte that is also payload gives two
// results and holds the input while the summary leaves the second output slot.
// Payload is sent before the status is known; drop it when the summary status
// is not ok. After the last byte the parser is back in its reset state, ready
// for the next file. No clearing pass follows reset.

module wav_chunk_stream_parser_top import wcsp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  wcsp_in_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output wcsp_out_t out_item_o,
  input  logic      out_stall_i
);

  logic       in_valid_q;
  wcsp_in_t   in_q;
  logic       out_ready;
  logic       advance;
  logic       in_take;
  wcsp_pair_t pair;

  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  wcsp_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .in_i  (in_q),
    .pair_o(pair)
  );

  wcsp_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (advance),
    .pair_i     (pair),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

`ifndef SYNTH
  a_summary_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_SUMMARY |-> out_item_o.final_res)
    else $error("summary item without final_res");

  a_payload_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_PAYLOAD |->
      !out_item_o.final_res && out_item_o.status == ST_OK)
    else $error("payload item carries summary fields");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && pair.second_vld |->
      pair.first_vld && pair.first.kind == KIND_PAYLOAD &&
      pair.second.kind == KIND_SUMMARY)
    else $error("second result without a leading payload item");
`endif

endmodule

[design/wcsp_parse.sv]
// wcsp_parse: chunk chain walk, fmt capture and result forming for one byte
// depends on wcsp_pkg

module wcsp_parse import wcsp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  wcsp_in_t   in_i,
  output wcsp_pair_t pair_o
);

  typedef enum logic [1:0] {
    FMT_IDLE,
    FMT_CAPTURE,
    FMT_DONE
  } fmt_state_e;

  localparam int unsigned PB = POSITION_BITS;

  logic [PB-1:0]      pos_q, pos_d;
  logic [CHAIN_W-1:0] hdr_end_q, hdr_end_d;
  fmt_state_e         fmt_q, fmt_d;
  logic               data_seen_q, data_seen_d;
  logic [55:0]        hist_q;
  logic [PB-1:0]      fmt_start_q, fmt_start_d;
  logic [63:0]        capt_q, capt_d;

  logic [7:0]   b;
  logic         eof;
  logic         indexed;
  logic [63:0]  word;
  logic [31:0]  size;
  logic [PB-1:0] fmt_ofs;
  logic         capturing;
  logic         fmt_last;
  logic         hdr_hit;
  logic [1:0]   st;
  wcsp_out_t    pay_res, sum_res;

  assign b       = in_i.file_byte;
  assign eof     = in_i.end_of_file;
  assign indexed = (pos_q != '1);
  assign word    = {hist_q, b};
  assign size    = {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign fmt_ofs = pos_q - fmt_start_q;
  assign capturing = indexed && (fmt_q == FMT_CAPTURE);
  assign fmt_last  = capturing && (fmt_ofs == PB'(FMT_OFS_BITS + 1));
  assign hdr_hit   = indexed && !eof && ({{(CHAIN_W-PB){1'b0}}, pos_q} == hdr_end_q);

  always_comb begin
    capt_d = capt_q;
    if (capturing) begin
      if (fmt_ofs == PB'(FMT_OFS_CHANNELS))           capt_d[7:0]   = b;
      else if (fmt_ofs == PB'(FMT_OFS_CHANNELS + 1))  capt_d[15:8]  = b;
      else if (fmt_ofs == PB'(FMT_OFS_RATE))          capt_d[23:16] = b;
      else if (fmt_ofs == PB'(FMT_OFS_RATE + 1))      capt_d[31:24] = b;
      else if (fmt_ofs == PB'(FMT_OFS_RATE + 2))      capt_d[39:32] = b;
      else if (fmt_ofs == PB'(FMT_OFS_RATE + 3))      capt_d[47:40] = b;
      else if (fmt_ofs == PB'(FMT_OFS_BITS))          capt_d[55:48] = b;
      else if (fmt_ofs == PB'(FMT_OFS_BITS + 1))      capt_d[63:56] = b;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    hdr_end_d   = hdr_end_q;
    fmt_d       = fmt_q;
    data_seen_d = data_seen_q;
    fmt_start_d = fmt_start_q;
    if (fmt_last) begin
      fmt_d = FMT_DONE;
    end
    if (hdr_hit) begin
      hdr_end_d = CHAIN_W'(pos_q) + CHAIN_W'(size) + CHAIN_W'(HDR_LEN);
      if (word[63:32] == ID_FMT && fmt_q == FMT_IDLE) begin
        fmt_d       = FMT_CAPTURE;
        fmt_start_d = pos_q - PB'(HDR_LEN - 1);
      end
      if (word[63:32] == ID_DATA) begin
        data_seen_d = 1'b1;
      end
    end
    if (eof) begin
      pos_d       = '0;
      hdr_end_d   = CHAIN_W'(PREAMBLE_LEN + HDR_LEN - 1);
      fmt_d       = FMT_IDLE;
      data_seen_d = 1'b0;
    end else if (indexed) begin
      pos_d = pos_q + PB'(1);
    end
  end

  always_comb begin
    if (pos_q < PB'(MIN_FILE_LEN - 1))          st = ST_SHORT;
    else if (!(fmt_q == FMT_DONE || fmt_last)) st = ST_NO_FMT;
    else if (!data_seen_q)                      st = ST_NO_DATA;
    else                                        st = ST_OK;
  end

  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = b;
    pay_res.status       = ST_OK;

    sum_res           = '0;
    sum_res.kind      = KIND_SUMMARY;
    sum_res.status    = st;
    sum_res.final_res = 1'b1;
    if (st == ST_OK || st == ST_NO_DATA) begin
      sum_res.channel_count = capt_d[15:0];
      sum_res.sample_rate   = capt_d[47:16];
      sum_res.sample_bits   = capt_d[63:48];
    end

    pair_o = '0;
    if (data_seen_q) begin
      pair_o.first_vld  = 1'b1;
      pair_o.first      = pay_res;
      pair_o.second_vld = eof;
      pair_o.second     = sum_res;
    end else begin
      pair_o.first_vld  = eof;
      pair_o.first      = sum_res;
      pair_o.second     = sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_end_q   <= CHAIN_W'(PREAMBLE_LEN + HDR_LEN - 1);
      fmt_q       <= FMT_IDLE;
      data_seen_q <= 1'b0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      hdr_end_q   <= hdr_end_d;
      fmt_q       <= fmt_d;
      data_seen_q <= data_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hist_q      <= word[55:0];
      fmt_start_q <= fmt_start_d;
      capt_q      <= capt_d;
    end
  end

endmodule

[design/wcsp_out.sv]
// wcsp_out: result register with a second slot for the summary that follows
// a last payload byte; depends on wcsp_pkg

module wcsp_out import wcsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wcsp_pair_t pair_i,
  output logic       ready_o,
  output logic       out_valid_o,
  output wcsp_out_t  out_item_o,
  input  logic       out_stall_i
);

  logic      out_valid_q;
  logic      pend_valid_q;
  wcsp_out_t out_q;
  wcsp_out_t pend_q;
  logic      free;

  assign free        = !out_valid_q || !out_stall_i;
  assign ready_o     = free && !pend_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (push_i) begin
        out_valid_q  <= pair_i.first_vld;
        pend_valid_q <= pair_i.second_vld;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (push_i) begin
        out_q  <= pair_i.first;
        pend_q <= pair_i.second;
      end
    end
  end

endmodule

[bench/wcsp_stream_checker.sv]
// wcsp_stream_checker: watches both channels of the wav chunk stream parser,
// predicts payload and summary items per byte and compares them in order
// depends on wcsp_pkg; instantiated by wav_chunk_stream_parser_top_tb
module wcsp_stream_checker import wcsp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  wcsp_in_t  in_item_i,
  input  logic      in_stall_i,
  input  logic      out_valid_i,
  input  wcsp_out_t out_item_i,
  input  logic      out_stall_i,
  output int        errors_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] POS_MAX   = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [63:0] CHAIN_MAX = 64'h1_FFFF_FFFF;

  typedef enum logic [1:0] {FMT_WAITING, FMT_CAPTURE, FMT_COMPLETE} fmt_phase_e;

  logic [63:0] byte_pos;
  logic [63:0] chain_next;
  logic [63:0] hdr_window;
  logic [63:0] fmt_base;
  fmt_phase_e  fmt_phase;
  logic        in_data;
  logic [31:0] pcm_count;
  logic [63:0] fmt_fields;

  wcsp_out_t parsed_q[$];
  wcsp_out_t want;
  int        err_count = 0;

  assign errors_o = err_count;

  function automatic void clear_state();
    byte_pos   = '0;
    chain_next = 64'(PREAMBLE_LEN);
    hdr_window = '0;
    fmt_base   = '0;
    fmt_phase  = FMT_WAITING;
    in_data    = 1'b0;
    pcm_count  = '0;
    fmt_fields = '0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [63:0] p, d, span, nxt;
    logic [31:0] id, raw;
    logic        indexed, was_data;
    wcsp_out_t   r;
    int          sh;
    p        = byte_pos;
    indexed  = p < POS_MAX;
    was_data = in_data;
    hdr_window = {hdr_window[55:0], b};

    if (indexed && fmt_phase == FMT_CAPTURE) begin
      d  = p - fmt_base;
      sh = -1;
      if (d == FMT_OFS_CHANNELS || d == FMT_OFS_CHANNELS + 1) begin
        sh = int'(d - FMT_OFS_CHANNELS) * 8;
      end else if (d >= FMT_OFS_RATE && d <= FMT_OFS_RATE + 3) begin
        sh = 16 + int'(d - FMT_OFS_RATE) * 8;
      end else if (d == FMT_OFS_BITS || d == FMT_OFS_BITS + 1) begin
        sh = 48 + int'(d - FMT_OFS_BITS) * 8;
      end
      if (sh >= 0) fmt_fields[sh +: 8] = b;
      if (d == FMT_OFS_BITS + 1) fmt_phase = FMT_COMPLETE;
    end

    if (indexed && !eof && chain_next <= CHAIN_MAX - 64'd7 && p == chain_next + 64'd7) begin
      id   = hdr_window[63:32];
      raw  = hdr_window[31:0];
      span = {32'd0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      nxt  = chain_next + 64'(HDR_LEN) + span;
      if (id == ID_FMT && fmt_phase == FMT_WAITING) begin
        fmt_phase = FMT_CAPTURE;
        fmt_base  = chain_next;
      end
      if (id == ID_DATA) in_data = 1'b1;
      chain_next = (nxt > CHAIN_MAX) ? CHAIN_MAX : nxt;
    end

    if (was_data) begin
      if (pcm_count != '1) pcm_count++;
      r              = '0;
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      parsed_q.push_back(r);
    end

    if (eof) begin
      r           = '0;
      r.kind      = KIND_SUMMARY;
      r.final_res = 1'b1;
      if (p + 64'd1 < 64'(MIN_FILE_LEN)) r.status = ST_SHORT;
      else if (fmt_phase != FMT_COMPLETE) r.status = ST_NO_FMT;
      else if (!in_data || pcm_count == 0) r.status = ST_NO_DATA;
      else r.status = ST_OK;
      if (r.status == ST_OK || r.status == ST_NO_DATA) begin
        r.channel_count = fmt_fields[15:0];
        r.sample_rate   = fmt_fields[47:16];
        r.sample_bits   = fmt_fields[63:48];
      end
      parsed_q.push_back(r);
      clear_state();
    end else if (indexed) begin
      byte_pos = p + 64'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      parsed_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) parse_byte(in_item_i.file_byte, in_item_i.end_of_file);
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $error("item with nothing expected: %p", out_item_i);
          err_count++;
        end else begin
          want = parsed_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item_i.kind));
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_item_i.payload_byte));
          check_field("status", 32'(want.status), 32'(out_item_i.status));
          check_field("sample_rate", want.sample_rate, out_item_i.sample_rate);
          check_field("channel_count", 32'(want.channel_count), 32'(out_item_i.channel_count));
          check_field("sample_bits", 32'(want.sample_bits), 32'(out_item_i.sample_bits));
          check_field("final_res", 32'(want.final_res), 32'(out_item_i.final_res));
        end
      end
      pending_o <= parsed_q.size();
    end
  end

endmodule

[bench/wav_chunk_stream_parser_top_tb.sv]
// wav_chunk_stream_parser_top_tb: builds wav files byte by byte (well formed,
// truncated, reordered, overlapping, oversized and noise) with random idling
// depends on wcsp_pkg, wav_chunk_stream_parser_top and wcsp_stream_checker
module wav_chunk_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wcsp_pkg::*;

  localparam int RESET_CYCLES   = 3;
  localparam int ITEMS_TARGET   = 1900;
  localparam int TAIL_ITEMS     = 200;
  localparam int PRESS_AT       = 300;
  localparam int LONG_HOLD      = 120;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    SC_PLAIN, SC_TRUNC, SC_FMT_LATE, SC_OVERLAP, SC_HUGE, SC_NO_DATA, SC_NOISE, SC_CORRUPT
  } wav_shape_e;
  localparam int NUM_SHAPES = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  wcsp_in_t  in_item;
  logic      in_stall;
  logic      out_valid;
  wcsp_out_t out_item;
  logic      out_stall;
  int        mismatches;
  int        pending;

  logic       [7:0] file_q[$];
  int               bytes_sent;
  int               tx_level;
  logic             calm_tail;

  wav_chunk_stream_parser_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_stall_i (out_stall)
  );

  wcsp_stream_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_item_i  (out_item),
    .out_stall_i (out_stall),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic push_rand(input int n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[i*8 +: 8]);
  endtask

  task automatic push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[i*8 +: 8]);
  endtask

  task automatic add_chunk(input logic [31:0] id, input logic [31:0] len, input int body_n);
    push_be32(id);
    push_le32(len);
    push_rand(body_n);
  endtask

  task automatic build_wav(input int shape);
    int          fmt_len, pay_len, cut, k;
    logic [31:0] junk_len;
    file_q.delete();
    if (shape == SC_NOISE) begin
      push_rand($urandom_range(1, 90));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        push_rand(PREAMBLE_LEN);
      end else begin
        push_be32("RIFF");
        push_rand(4);
        push_be32("WAVE");
      end
      if (shape == SC_HUGE) begin
        junk_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        add_chunk($urandom, junk_len, $urandom_range(0, 4));
      end else if (shape == SC_TRUNC || $urandom_range(0, 3) == 0) begin
        junk_len = $urandom_range(0, shape == SC_TRUNC ? 40 : 6);
        add_chunk($urandom, junk_len, int'(junk_len));
      end
      if (shape == SC_OVERLAP) begin
        fmt_len = $urandom_range(0, 14);
      end else begin
        case ($urandom_range(0, 3))
          0: fmt_len = 16;
          1: fmt_len = 18;
          2: fmt_len = 40;
          default: fmt_len = $urandom_range(16, 24);
        endcase
      end
      pay_len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      if (shape == SC_FMT_LATE) begin
        add_chunk(ID_DATA, pay_len, pay_len);
        add_chunk(ID_FMT, fmt_len, fmt_len);
      end else begin
        add_chunk(ID_FMT, fmt_len, fmt_len);
        if (shape != SC_NO_DATA) begin
          add_chunk(ID_DATA, ($urandom_range(0, 7) == 0) ? $urandom : pay_len, pay_len);
        end
      end
      if (shape == SC_NO_DATA || $urandom_range(0, 2) == 0) begin
        junk_len = $urandom_range(0, 6);
        add_chunk($urandom, junk_len, int'(junk_len));
      end
    end
    if (shape == SC_CORRUPT) begin
      k = $urandom_range(0, file_q.size() - 1);
      file_q[k] = file_q[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (shape == SC_TRUNC || $urandom_range(0, 7) == 0) begin
      cut = $urandom_range((file_q.size() + 1) / 2, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof);
    wcsp_in_t item;
    if (!calm_tail && tx_level != 0 && $urandom_range(0, 15) < tx_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item.file_byte   = b;
    item.end_of_file = eof;
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    tx_level = $urandom_range(0, 3);
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  initial begin : rx_side
    int   hold, level, cyc;
    logic held;
    hold = 0;
    level = 0;
    cyc = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) level = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!held && bytes_sent >= PRESS_AT) begin
        held = 1'b1;
        hold = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!calm_tail && level != 0 && $urandom_range(0, 15) < level) begin
        hold = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) break;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int f, shape;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    calm_tail = 1'b0;
    bytes_sent = 0;
    tx_level = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte files, then a short file whose last byte is payload
    file_q = '{8'hFF};
    send_file();
    file_q = '{8'h00};
    send_file();
    file_q.delete();
    push_be32("RIFF");
    push_le32(32'hFFFF_FFFF);
    push_be32("WAVE");
    add_chunk(ID_DATA, 32'd0, 1);
    send_file();

    f = 0;
    while (bytes_sent < ITEMS_TARGET) begin
      if (f < 2 * NUM_SHAPES) begin
        shape = f % NUM_SHAPES;
      end else begin
        shape = $urandom_range(0, NUM_SHAPES + 2);
        if (shape >= NUM_SHAPES) shape = SC_PLAIN;
      end
      build_wav(shape);
      send_file();
      f++;
      if (bytes_sent >= ITEMS_TARGET - TAIL_ITEMS) calm_tail = 1'b1;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
